[rtl/ir_ac_pkg.sv]
// ---------------------------------------------------------------------------
// ir_ac_pkg
// Shared types, codes and lookup functions for the IR A/C pulse encoder.
// ---------------------------------------------------------------------------
`default_nettype none

package ir_ac_pkg;

  // Item operations
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_NEXT = 1'b1
  } op_t;

  // Kind of mark/space pair
  typedef enum logic [1:0] {
    SEG_HEADER = 2'd0,
    SEG_DATA   = 2'd1,
    SEG_STOP   = 2'd2
  } seg_kind_t;

  // Operating modes that matter to the encoding
  typedef enum logic [2:0] {
    MODE_COOL = 3'd0,
    MODE_HEAT = 3'd1,
    MODE_FAN  = 3'd2,
    MODE_DRY  = 3'd3,
    MODE_AUTO = 3'd4
  } mode_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TIME  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_SPACE = 1'd1;

  localparam int UNIT_W   = 12;
  localparam int DUR_W    = 16;
  localparam int CMD_BYTES = 3;

  localparam logic [UNIT_W-1:0] UNIT_TIME_RST  = 12'd550;
  localparam logic [DUR_W-1:0]  STOP_SPACE_RST = 16'd5230;

  localparam logic [7:0] CMD_PREAMBLE   = 8'hB2;
  localparam logic [3:0] PWR_ON_CODE    = 4'b1111;
  localparam logic [3:0] PWR_OFF_CODE   = 4'b1011;
  localparam logic [3:0] FAN_FORCED     = 4'b0001;
  localparam logic [3:0] TEMP_NONE_CODE = 4'b1110;
  localparam logic [7:0] TEMP_MIN       = 8'd17;
  localparam logic [7:0] TEMP_MAX       = 8'd30;

  // One queued pair descriptor
  typedef struct packed {
    seg_kind_t kind;
    logic      bit_val;
    logic      frame;
    logic      last;
  } pair_desc_t;

  function automatic logic [3:0] fan_nibble(input logic [1:0] fan);
    logic [3:0] code;
    case (fan)
      2'd0:    code = 4'hB;
      2'd1:    code = 4'h9;
      2'd2:    code = 4'h5;
      default: code = 4'h3;
    endcase
    return code;
  endfunction

  function automatic logic [3:0] mode_nibble(input logic [2:0] mode);
    logic [3:0] code;
    case (mode)
      MODE_COOL: code = 4'b0000;
      MODE_HEAT: code = 4'b1100;
      MODE_FAN:  code = 4'b0100;
      MODE_DRY:  code = 4'b0100;
      default:   code = 4'b1000;
    endcase
    return code;
  endfunction

  // Index is temperature minus 17, valid 0..13
  function automatic logic [3:0] temp_nibble(input logic [3:0] idx);
    logic [3:0] code;
    case (idx)
      4'd0:    code = 4'h0;
      4'd1:    code = 4'h1;
      4'd2:    code = 4'h3;
      4'd3:    code = 4'h2;
      4'd4:    code = 4'h6;
      4'd5:    code = 4'h7;
      4'd6:    code = 4'h5;
      4'd7:    code = 4'h4;
      4'd8:    code = 4'hC;
      4'd9:    code = 4'hD;
      4'd10:   code = 4'h9;
      4'd11:   code = 4'h8;
      4'd12:   code = 4'hA;
      4'd13:   code = 4'hB;
      default: code = TEMP_NONE_CODE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[rtl/ir_ac_front.sv]
// ---------------------------------------------------------------------------
// ir_ac_front
// Accepts items, encodes commands and tracks the frame position; pushes one
// pair descriptor per 'next' item while a transmission is running.
// ---------------------------------------------------------------------------
`default_nettype none

module ir_ac_front import ir_ac_pkg::*; #(
  parameter int DATA_BYTES = 3
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic       in_operation,
  input  wire logic [2:0] in_mode,
  input  wire logic [1:0] in_fan_speed,
  input  wire logic       in_power_on,
  input  wire logic [7:0] in_temperature,
  input  wire logic       q_full,
  output      logic       q_push,
  output      pair_desc_t q_wdata
);

  localparam int DataPairs = 16 * DATA_BYTES;
  localparam int PosW      = $clog2(DataPairs + 2);
  localparam logic [PosW-1:0] DataPairsC = PosW'(DataPairs);

  logic [CMD_BYTES-1:0][7:0] cmd_r, cmd_nxt;
  logic [PosW-1:0]           pos_r, pos_nxt;
  logic                      frame_r, frame_nxt;
  logic                      busy_r, busy_nxt;

  logic            accept;
  logic            is_next;
  logic [3:0]      fc;
  logic [3:0]      tc;
  logic [7:0]      temp_off;
  logic [PosW-1:0] b_idx;
  logic [PosW-5:0] pair_idx;
  logic [7:0]      sel_byte;
  logic [2:0]      bit_idx;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_next  = (op_t'(in_operation) == OP_NEXT);
  assign temp_off = in_temperature - TEMP_MIN;

  // Command field codes
  always_comb begin
    if (in_mode inside {MODE_DRY, [MODE_AUTO:3'd7]}) begin
      fc = FAN_FORCED;
    end else begin
      fc = fan_nibble(in_fan_speed);
    end
    if (in_mode == MODE_FAN || in_temperature < TEMP_MIN || in_temperature > TEMP_MAX) begin
      tc = TEMP_NONE_CODE;
    end else begin
      tc = temp_nibble(temp_off[3:0]);
    end
  end

  // Current data bit: byte pair, true/complement, MSB first
  always_comb begin
    b_idx    = pos_r - 1'b1;
    pair_idx = b_idx[PosW-1:4];
    bit_idx  = 3'd7 - b_idx[2:0];
    sel_byte = '0;
    for (int i = 0; i < CMD_BYTES; i++) begin
      if (int'(pair_idx) == i) begin
        sel_byte = cmd_r[i];
      end
    end
    if (b_idx[3]) begin
      sel_byte = ~sel_byte;
    end
  end

  always_comb begin
    cmd_nxt           = cmd_r;
    pos_nxt           = pos_r;
    frame_nxt         = frame_r;
    busy_nxt          = busy_r;
    q_push            = 1'b0;
    q_wdata.kind      = SEG_HEADER;
    q_wdata.bit_val   = sel_byte[bit_idx];
    q_wdata.frame     = frame_r;
    q_wdata.last      = 1'b0;
    if (accept && !is_next) begin
      cmd_nxt[0] = CMD_PREAMBLE;
      cmd_nxt[1] = {fc, (in_power_on ? PWR_ON_CODE : PWR_OFF_CODE)};
      cmd_nxt[2] = {tc, mode_nibble(in_mode)};
      pos_nxt    = '0;
      frame_nxt  = 1'b0;
      busy_nxt   = 1'b1;
    end else if (accept && busy_r) begin
      q_push = 1'b1;
      if (pos_r == '0) begin
        q_wdata.kind = SEG_HEADER;
        pos_nxt      = PosW'(1);
      end else if (pos_r <= DataPairsC) begin
        q_wdata.kind = SEG_DATA;
        pos_nxt      = pos_r + 1'b1;
      end else begin
        q_wdata.kind = SEG_STOP;
        q_wdata.last = frame_r;
        pos_nxt      = '0;
        frame_nxt    = !frame_r;
        // drop busy after the second frame's stop pair
        if (frame_r) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (!rst_n) begin
      pos_r   <= '0;
      frame_r <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      frame_r <= frame_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/ir_ac_fifo.sv]
// ---------------------------------------------------------------------------
// ir_ac_fifo
// Short descriptor queue between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

module ir_ac_fifo import ir_ac_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire pair_desc_t wdata,
  output      logic       full,
  input  wire logic       pop,
  output      logic       valid,
  output      pair_desc_t rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC  = CW'(DEPTH);

  pair_desc_t      mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == DepthC);
  assign valid   = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/ir_ac_back.sv]
// ---------------------------------------------------------------------------
// ir_ac_back
// Holds the timing registers, turns pair descriptors into mark/space
// durations and drives the registered result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module ir_ac_back import ir_ac_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DUR_W-1:0]     cfg_wdata,
  input  wire logic                 q_valid,
  input  wire pair_desc_t           q_rdata,
  output      logic                 q_pop,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [DUR_W-1:0]     out_mark_time,
  output      logic [DUR_W-1:0]     out_space_time,
  output      logic [1:0]           out_segment_kind,
  output      logic                 out_frame_number,
  output      logic                 out_last_pair
);

  logic [UNIT_W-1:0] unit_r;
  logic [DUR_W-1:0]  stop_space_r;

  logic              out_valid_r, out_valid_nxt;
  logic [DUR_W-1:0]  mark_r, mark_nxt;
  logic [DUR_W-1:0]  space_r, space_nxt;
  seg_kind_t         kind_r;
  logic              frame_r;
  logic              last_r;

  logic [DUR_W-1:0]  unit_x1;
  logic [DUR_W-1:0]  unit_x3;
  logic [DUR_W-1:0]  unit_x8;

  assign unit_x1 = DUR_W'(unit_r);
  assign unit_x3 = DUR_W'({unit_r, 1'b0}) + DUR_W'(unit_r);
  assign unit_x8 = DUR_W'({unit_r, 3'b000});

  // Refill the output register when it is empty or being taken
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    case (q_rdata.kind)
      SEG_HEADER: begin
        mark_nxt  = unit_x8;
        space_nxt = unit_x8;
      end
      SEG_DATA: begin
        mark_nxt  = unit_x1;
        space_nxt = q_rdata.bit_val ? unit_x3 : unit_x1;
      end
      default: begin
        mark_nxt  = unit_x1;
        space_nxt = stop_space_r;
      end
    endcase
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r       <= UNIT_TIME_RST;
      stop_space_r <= STOP_SPACE_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_UNIT_TIME) begin
        unit_r <= cfg_wdata[UNIT_W-1:0];
      end else if (cfg_index == CFG_STOP_SPACE) begin
        stop_space_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mark_r  <= mark_nxt;
      space_r <= space_nxt;
      kind_r  <= q_rdata.kind;
      frame_r <= q_rdata.frame;
      last_r  <= q_rdata.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mark_time    = mark_r;
  assign out_space_time   = space_r;
  assign out_segment_kind = kind_r;
  assign out_frame_number = frame_r;
  assign out_last_pair    = last_r;

endmodule

`default_nettype wire

[rtl/ir_ac_remote_pulse_encoder.sv]
// ---------------------------------------------------------------------------
// ir_ac_remote_pulse_encoder
// Encodes an A/C remote command and plays it out as mark/space pairs,
// one pair per 'next' item, header + data bits + stop, frame sent twice.
// ---------------------------------------------------------------------------
//  port group | handshake            | payload
//  in_        | in_valid / in_stall  | operation, mode, fan_speed, power_on,
//             |                      | temperature
//  out_       | out_valid / out_stall| mark_time, space_time, segment_kind,
//             |                      | frame_number, last_pair
//  cfg_       | cfg_wr_en            | cfg_index, cfg_wdata
//
//  One item per cycle while in_stall is low; a 'next' item's pair goes into
//  the queue at the accepting edge, then into the output register for out_.
//  Loads and 'next' items while idle produce no result.
//  Reset (rst_n low, synchronous) empties the queue and output register,
//  restores the timing registers and leaves the encoder idle.
//  out_stall backs up the two-entry queue; in_stall rises only when it fills.
// ---------------------------------------------------------------------------
`default_nettype none

module ir_ac_remote_pulse_encoder import ir_ac_pkg::*; #(
  parameter int DATA_BYTES = 3,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DUR_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic                 in_operation,
  input  wire logic [2:0]           in_mode,
  input  wire logic [1:0]           in_fan_speed,
  input  wire logic                 in_power_on,
  input  wire logic [7:0]           in_temperature,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [DUR_W-1:0]     out_mark_time,
  output      logic [DUR_W-1:0]     out_space_time,
  output      logic [1:0]           out_segment_kind,
  output      logic                 out_frame_number,
  output      logic                 out_last_pair
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  pair_desc_t q_wdata;
  pair_desc_t q_rdata;

  ir_ac_front #(
    .DATA_BYTES (DATA_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_mode        (in_mode),
    .in_fan_speed   (in_fan_speed),
    .in_power_on    (in_power_on),
    .in_temperature (in_temperature),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  ir_ac_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  ir_ac_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .q_valid          (q_valid),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mark_time    (out_mark_time),
    .out_space_time   (out_space_time),
    .out_segment_kind (out_segment_kind),
    .out_frame_number (out_frame_number),
    .out_last_pair    (out_last_pair)
  );

endmodule

`default_nettype wire
